[rtl/dpsc_pkg.sv]
// Shared types and constants for the dual-channel PI speed controller.
// No dependencies; used by every module of the block.
package dpsc_pkg;

  localparam int SPEED_W  = 16;
  localparam int ERR_W    = SPEED_W + 1;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 23;
  localparam int INTEG_W  = 24;
  localparam int DRIVE_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 2'd0,
    REG_INT_GAIN    = 2'd1,
    REG_INTEG_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  int_gain;
    logic [LIMIT_W-1:0] integ_limit;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic                    ch;
    logic                    active;
    logic signed [ERR_W-1:0] err;
  } item_t;

endpackage

[rtl/dpsc_front.sv]
// Front end: accepts input transactions, forms the speed error and
// classifies each item. Depends on dpsc_pkg.
module dpsc_front #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [2*dpsc_pkg::SPEED_W-1:0]         in_tdata,
  input  logic                                   in_tuser,
  output logic                                   push,
  output dpsc_pkg::item_t                        push_item,
  input  logic                                   q_ready
);

  logic            f_vld_r, f_vld_nxt;
  dpsc_pkg::item_t f_item_r, f_item_nxt;
  logic signed [dpsc_pkg::SPEED_W-1:0] meas, targ;
  logic            accept;

  assign meas = signed'(in_tdata[dpsc_pkg::SPEED_W-1:0]);
  assign targ = signed'(in_tdata[2*dpsc_pkg::SPEED_W-1:dpsc_pkg::SPEED_W]);

  assign push      = f_vld_r && q_ready;
  assign push_item = f_item_r;
  assign in_tready = !f_vld_r || push;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    f_vld_nxt  = f_vld_r;
    f_item_nxt = f_item_r;
    if (push) begin
      f_vld_nxt = 1'b0;
    end
    if (accept) begin
      f_vld_nxt         = 1'b1;
      f_item_nxt.ch     = in_tuser;
      f_item_nxt.active = (targ != '0) && (32'(in_tuser) < NUM_CHANNELS);
      f_item_nxt.err    = dpsc_pkg::ERR_W'(targ) - dpsc_pkg::ERR_W'(meas);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_item_r <= f_item_nxt;
  end

endmodule

[rtl/dpsc_queue.sv]
// Short queue between front and back so each side stalls on its own.
// Depends on dpsc_pkg.
module dpsc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dpsc_pkg::item_t push_item,
  output logic            ready,
  output logic            q_vld,
  output dpsc_pkg::item_t q_item,
  input  logic            pop
);

  dpsc_pkg::item_t                   mem_r [dpsc_pkg::QUEUE_DEPTH];
  logic [dpsc_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [dpsc_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [dpsc_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                              full;

  assign full   = (cnt_r == dpsc_pkg::QCNT_W'(dpsc_pkg::QUEUE_DEPTH));
  assign ready  = !full || pop;
  assign q_vld  = (cnt_r != '0);
  assign q_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == dpsc_pkg::QPTR_W'(dpsc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == dpsc_pkg::QPTR_W'(dpsc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_vld)
    else $error("queue read while empty");
`endif

endmodule

[rtl/dpsc_back.sv]
// Back end: integrator update with clamp, gain multiplies, then sum,
// floor scaling and saturation into the output register. Depends on dpsc_pkg.
module dpsc_back #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dpsc_pkg::cfg_t                cfg,
  input  logic                          q_vld,
  input  dpsc_pkg::item_t               q_item,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dpsc_pkg::DRIVE_W-1:0]  out_tdata,
  output logic                          out_tuser
);

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PT_W   = dpsc_pkg::ERR_W + dpsc_pkg::GAIN_W + 1;
  localparam int IT_W   = dpsc_pkg::INTEG_W + dpsc_pkg::GAIN_W + 1;
  localparam int SUM_W  = IT_W + 1;
  localparam int Q_W    = SUM_W - 8;
  localparam int CLMP_W = dpsc_pkg::INTEG_W + 1;

  localparam logic signed [Q_W-1:0] DRIVE_MAX = Q_W'(signed'(24'sh7FFFFF));
  localparam logic signed [Q_W-1:0] DRIVE_MIN = Q_W'(signed'(24'sh800000));

  logic signed [dpsc_pkg::INTEG_W-1:0] integ_r [NUM_CHANNELS];

  logic                        s1_vld_r, s1_vld_nxt;
  logic                        s1_ch_r;
  logic                        s1_active_r;
  logic signed [PT_W-1:0]      s1_pterm_r;
  logic signed [IT_W-1:0]      s1_iterm_r;

  logic                        out_vld_r, out_vld_nxt;
  logic                        out_ch_r;
  logic [dpsc_pkg::DRIVE_W-1:0] out_drive_r;

  logic                        out_adv, s1_adv;
  logic [CH_W-1:0]             idx;
  logic signed [dpsc_pkg::INTEG_W-1:0] old_integ;
  logic signed [CLMP_W-1:0]    sum_integ, lim, nlim, clamp_integ;
  logic                        wr_en;
  logic signed [SUM_W-1:0]     acc;
  logic signed [Q_W-1:0]       scaled;
  logic [dpsc_pkg::DRIVE_W-1:0] sat_drive;

  assign out_adv = !out_vld_r || out_tready;
  assign s1_adv  = !s1_vld_r || out_adv;
  assign pop     = q_vld && s1_adv;
  assign wr_en   = pop && q_item.active;

  assign idx       = CH_W'(q_item.ch);
  assign old_integ = q_item.active ? integ_r[idx] : '0;

  // integrator update and clamp
  assign sum_integ = CLMP_W'(old_integ) + CLMP_W'(q_item.err);
  assign lim       = signed'(CLMP_W'(cfg.integ_limit));
  assign nlim      = -lim;

  always_comb begin
    if (sum_integ > lim) begin
      clamp_integ = lim;
    end else if (sum_integ < nlim) begin
      clamp_integ = nlim;
    end else begin
      clamp_integ = sum_integ;
    end
  end

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_integ
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        integ_r[i] <= '0;
      end else if (wr_en && (idx == CH_W'(i))) begin
        integ_r[i] <= clamp_integ[dpsc_pkg::INTEG_W-1:0];
      end
    end
  end

  assign s1_vld_nxt = s1_adv ? pop : s1_vld_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ch_r     <= q_item.ch;
      s1_active_r <= q_item.active;
      s1_pterm_r  <= PT_W'(q_item.err) * signed'({1'b0, cfg.prop_gain});
      s1_iterm_r  <= IT_W'(old_integ) * signed'({1'b0, cfg.int_gain});
    end
  end

  // floor divide by 256, saturate to drive width
  assign acc    = SUM_W'(s1_pterm_r) + SUM_W'(s1_iterm_r);
  assign scaled = acc[SUM_W-1:8];

  always_comb begin
    if (!s1_active_r) begin
      sat_drive = '0;
    end else if (scaled > DRIVE_MAX) begin
      sat_drive = DRIVE_MAX[dpsc_pkg::DRIVE_W-1:0];
    end else if (scaled < DRIVE_MIN) begin
      sat_drive = DRIVE_MIN[dpsc_pkg::DRIVE_W-1:0];
    end else begin
      sat_drive = scaled[dpsc_pkg::DRIVE_W-1:0];
    end
  end

  assign out_vld_nxt = out_adv ? s1_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (out_adv && s1_vld_r) begin
      out_ch_r    <= s1_ch_r;
      out_drive_r <= sat_drive;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_ch_r;

`ifndef SYNTHESIS
  a_integ_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (clamp_integ <= lim && clamp_integ >= nlim))
    else $error("integrator written outside clamp");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_adv) |=> (s1_vld_r && $stable(s1_pterm_r) && $stable(s1_iterm_r)))
    else $error("product stage lost data under stall");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_adv) |-> !pop)
    else $error("queue popped into occupied product stage");
`endif

endmodule

[rtl/dual_pi_speed_controller_core.sv]
// Top level of the dual-channel PI speed controller: configuration
// registers plus front, queue and back. Depends on dpsc_pkg and submodules.
//
// Usage:
//   in_*  : one transaction per control update. in_tuser is the channel,
//           in_tdata carries measured speed and target speed (Q8.8 signed).
//   out_* : one transaction per input. out_tuser is the channel, out_tdata
//           the saturated drive value (Q16.8 signed, 24 bits).
//   cfg_* : write-only registers (0 proportional gain, 1 integral gain,
//           2 integrator limit); write only while no item is in flight.
// An accepted input passes the front register, queue, product stage and output
// register before out_tvalid rises. Throughput is one item per cycle while
// out_tready is high: the integrator read-modify-write of a channel completes
// in the cycle its item leaves the queue, so same-channel items can follow
// back to back; the two gain multiplies sit in their own register stage.
// Reset clears both integrators, sets proportional gain to 1.0 and the
// integral gain and limit to zero, and empties the pipeline.
// When out_tready is low the output register holds; the product stage, the
// two-entry queue and the front register keep absorbing input until they
// fill (five items held in all), then in_tready drops.
module dual_pi_speed_controller_core #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,   // measured_speed, target_speed
  input  logic                               in_tuser,   // channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dpsc_pkg::DRIVE_W-1:0]       out_tdata,  // drive_value
  output logic                               out_tuser,  // drive_channel
  input  logic                               cfg_we,
  input  logic [dpsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpsc_pkg::LIMIT_W-1:0]       cfg_wdata
);

  dpsc_pkg::cfg_t  cfg_r;
  logic            push, q_ready, q_vld, pop;
  dpsc_pkg::item_t push_item, q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= dpsc_pkg::GAIN_W'(256);
      cfg_r.int_gain    <= '0;
      cfg_r.integ_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dpsc_pkg::REG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_wdata[dpsc_pkg::GAIN_W-1:0];
        dpsc_pkg::REG_INT_GAIN:    cfg_r.int_gain    <= cfg_wdata[dpsc_pkg::GAIN_W-1:0];
        dpsc_pkg::REG_INTEG_LIMIT: cfg_r.integ_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dpsc_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready)
  );

  dpsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .ready     (q_ready),
    .q_vld     (q_vld),
    .q_item    (q_item),
    .pop       (pop)
  );

  dpsc_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_vld      (q_vld),
    .q_item     (q_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[tb/tb_dual_pi_speed_controller_core.sv]
// Testbench for dual_pi_speed_controller_core: directed and random speed updates
// with config sweeps, checked against a PI drive predictor in a scoreboard class.
// Depends on dpsc_pkg and the controller RTL.
module tb_dual_pi_speed_controller_core;

  localparam int NUM_CH      = 2;
  localparam int LATENCY     = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [dpsc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [dpsc_pkg::SPEED_W-1:0] SPEED_MIN = 16'h8000;
  localparam logic [dpsc_pkg::SPEED_W-1:0] SPEED_MAX = 16'h7FFF;
  localparam longint DRIVE_HI = 64'sd8388607;
  localparam longint DRIVE_LO = -64'sd8388608;

  typedef struct {
    logic                                ch;
    logic signed [dpsc_pkg::DRIVE_W-1:0] drive;
  } drive_t;

  class drive_scoreboard;
    logic [dpsc_pkg::GAIN_W-1:0]         prop_gain;
    logic [dpsc_pkg::GAIN_W-1:0]         int_gain;
    logic [dpsc_pkg::LIMIT_W-1:0]        integ_limit;
    logic signed [dpsc_pkg::INTEG_W-1:0] integ [NUM_CH];
    drive_t                              expected_drives[$];
    int unsigned                         errors;

    function new();
      prop_gain   = 16'd256;
      int_gain    = '0;
      integ_limit = '0;
      foreach (integ[i]) integ[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [dpsc_pkg::CFG_IDX_W-1:0] idx,
                            logic [dpsc_pkg::LIMIT_W-1:0] data);
      case (idx)
        dpsc_pkg::REG_PROP_GAIN:   prop_gain   = data[dpsc_pkg::GAIN_W-1:0];
        dpsc_pkg::REG_INT_GAIN:    int_gain    = data[dpsc_pkg::GAIN_W-1:0];
        dpsc_pkg::REG_INTEG_LIMIT: integ_limit = data;
        default: ;
      endcase
    endfunction

    function void note_update(logic ch, logic signed [dpsc_pkg::SPEED_W-1:0] meas,
                              logic signed [dpsc_pkg::SPEED_W-1:0] targ);
      longint err, old, acc, drv, nxt, lim;
      drive_t d;
      drv = 0;
      if (targ != 0 && int'(ch) < NUM_CH) begin
        err = longint'(targ) - longint'(meas);
        old = longint'(integ[ch]);
        acc = err * longint'(prop_gain) + old * longint'(int_gain);
        drv = acc >>> 8;
        if (drv > DRIVE_HI) drv = DRIVE_HI;
        else if (drv < DRIVE_LO) drv = DRIVE_LO;
        lim = longint'(integ_limit);
        nxt = old + err;
        if (nxt > lim) nxt = lim;
        else if (nxt < -lim) nxt = -lim;
        integ[ch] = nxt[dpsc_pkg::INTEG_W-1:0];
      end
      d.ch    = ch;
      d.drive = drv[dpsc_pkg::DRIVE_W-1:0];
      expected_drives.push_back(d);
    endfunction

    function void check_drive(logic ch, logic [dpsc_pkg::DRIVE_W-1:0] drive);
      drive_t d;
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected drive transaction ch %0d value %0d",
                 $time, ch, $signed(drive));
        errors++;
        return;
      end
      d = expected_drives.pop_front();
      if (d.ch !== ch) begin
        $display("%0t: drive_channel mismatch: expected %0d, got %0d", $time, d.ch, ch);
        errors++;
      end
      if (d.drive !== drive) begin
        $display("%0t: drive_value mismatch ch %0d: expected %0d, got %0d",
                 $time, d.ch, d.drive, $signed(drive));
        errors++;
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [31:0]                    in_tdata;   // measured_speed, target_speed
  logic                           in_tuser;   // channel
  logic                           out_tvalid;
  logic                           out_tready;
  logic [dpsc_pkg::DRIVE_W-1:0]   out_tdata;  // drive_value
  logic                           out_tuser;  // drive_channel
  logic                           cfg_we;
  logic [dpsc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dpsc_pkg::LIMIT_W-1:0]   cfg_wdata;

  drive_scoreboard tracker;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_left;
  int cycle_count;

  dual_pi_speed_controller_core #(.NUM_CHANNELS(NUM_CH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // transaction monitor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      tracker.note_update(in_tuser, in_tdata[15:0], in_tdata[31:16]);
    if (rst_n && out_tvalid && out_tready)
      tracker.check_drive(out_tuser, out_tdata);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver backpressure
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_tready = 1'b0;
        rx_hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_update(input logic ch, input logic [dpsc_pkg::SPEED_W-1:0] meas,
                             input logic [dpsc_pkg::SPEED_W-1:0] targ);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata  = $urandom;
      in_tuser  = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = ch;
    in_tdata  = {targ, meas};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(input logic [dpsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dpsc_pkg::LIMIT_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [dpsc_pkg::SPEED_W-1:0] rand_speed();
    case ($urandom_range(7))
      0:       return SPEED_MIN;
      1:       return SPEED_MAX;
      default: return dpsc_pkg::SPEED_W'($urandom);
    endcase
  endfunction

  function automatic logic [dpsc_pkg::LIMIT_W-1:0] rand_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return dpsc_pkg::LIMIT_W'($urandom_range(1, 1024));
      default: return dpsc_pkg::LIMIT_W'($urandom);
    endcase
  endfunction

  task automatic random_config();
    logic [dpsc_pkg::LIMIT_W-1:0] ig;
    int unsigned                  soft_lim;
    ig = rand_gain();
    write_reg(dpsc_pkg::REG_PROP_GAIN, rand_gain());
    write_reg(dpsc_pkg::REG_INT_GAIN, ig);
    soft_lim = (ig[dpsc_pkg::GAIN_W-1:0] != 0) ?
               6553600 / ig[dpsc_pkg::GAIN_W-1:0] : 23'h7FFFFF;
    case ($urandom_range(4))
      0:       write_reg(dpsc_pkg::REG_INTEG_LIMIT, '0);
      1:       write_reg(dpsc_pkg::REG_INTEG_LIMIT, '1);
      2:       write_reg(dpsc_pkg::REG_INTEG_LIMIT,
                         (soft_lim > 23'h7FFFFF) ? '1 : dpsc_pkg::LIMIT_W'(soft_lim));
      default: write_reg(dpsc_pkg::REG_INTEG_LIMIT,
                         dpsc_pkg::LIMIT_W'($urandom_range(0, 200000)));
    endcase
    write_reg(REG_SPARE, dpsc_pkg::LIMIT_W'($urandom));
  endtask

  task automatic random_block(input int n_items);
    logic                         ch;
    logic [dpsc_pkg::SPEED_W-1:0] meas;
    logic [dpsc_pkg::SPEED_W-1:0] targ;
    for (int i = 0; i < n_items; i++) begin
      ch = 1'($urandom_range(1));
      case ($urandom_range(3))
        0: begin
          meas = rand_speed();
          targ = rand_speed();
        end
        1: begin
          meas = rand_speed();
          targ = $urandom_range(1) ? '0 : rand_speed();
        end
        2: begin  // positive error, drives integrator up
          meas = dpsc_pkg::SPEED_W'($urandom_range(16'h8000, 16'hFFFF));
          targ = dpsc_pkg::SPEED_W'($urandom_range(16'h0001, 16'h7FFF));
        end
        default: begin  // negative error
          meas = dpsc_pkg::SPEED_W'($urandom_range(16'h0000, 16'h7FFF));
          targ = dpsc_pkg::SPEED_W'($urandom_range(16'h8000, 16'hFFFF));
        end
      endcase
      send_update(ch, meas, targ);
    end
  endtask

  task automatic directed_checks();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // reset gains: unity proportional, no integral term
    send_update(1'b0, 16'h0000, 16'h0001);
    send_update(1'b1, SPEED_MIN, SPEED_MAX);
    send_update(1'b0, SPEED_MAX, SPEED_MIN);
    send_update(1'b1, 16'h1234, 16'h0000);
    send_update(1'b0, 16'h0500, 16'h0500);
    wait_drained();
    // full-scale gains, upper wdata bits set
    write_reg(dpsc_pkg::REG_PROP_GAIN, '1);
    write_reg(dpsc_pkg::REG_INT_GAIN, '1);
    write_reg(dpsc_pkg::REG_INTEG_LIMIT, '1);
    write_reg(REG_SPARE, 23'h555555);
    repeat (4) send_update(1'b1, SPEED_MIN, SPEED_MAX);
    send_update(1'b1, 16'h0100, 16'h0000);
    repeat (2) send_update(1'b0, SPEED_MAX, SPEED_MIN);
    wait_drained();
    // limit dropped below the held integrators
    write_reg(dpsc_pkg::REG_INTEG_LIMIT, 23'd1000);
    send_update(1'b1, 16'h0000, 16'h0001);
    send_update(1'b1, 16'h0000, 16'h0001);
    send_update(1'b0, 16'h0000, 16'hFFFF);
    wait_drained();
    write_reg(dpsc_pkg::REG_INT_GAIN, '0);
    send_update(1'b1, 16'h0100, 16'h0200);
    send_update(1'b0, 16'h0200, 16'h0100);
    wait_drained();
    write_reg(dpsc_pkg::REG_INTEG_LIMIT, '0);
    write_reg(dpsc_pkg::REG_INT_GAIN, 23'd256);
    write_reg(dpsc_pkg::REG_PROP_GAIN, '0);
    send_update(1'b0, 16'h0000, 16'h7000);
    send_update(1'b0, 16'h0000, 16'h7000);
    wait_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_left = 0;
    cycle_count  = 0;
    tracker      = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_checks();

    for (int blk = 0; blk < 8; blk++) begin
      if (blk < 3) begin
        tx_idle_pct = 23;
        rx_idle_pct = 69;
      end else if (blk < 6) begin
        tx_idle_pct = 69;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_config();
      if (blk == 6) begin
        // long output stall while input keeps coming
        @(posedge clk);
        rx_hold_left = 300;
      end
      random_block(100);
      wait_drained();
    end

    repeat (LATENCY * 4) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
